// ===== rtl/core/lfpd_pkg.sv =====
`default_nettype none
package lfpd_pkg;

    localparam int C_NUM_SENSORS = 8;
    localparam int C_DIV_STEPS   = 12;

    typedef logic signed [4:0] t_weight;

    // sensor weights in units of one half, sensor 1 first
    localparam t_weight C_WEIGHT_HALVES [C_NUM_SENSORS] =
        '{-5'sd8, -5'sd6, -5'sd4, -5'sd1, 5'sd1, 5'sd4, 5'sd6, 5'sd8};

    localparam logic [11:0] C_DRIVE_LIMIT_RST = 12'd500;
    localparam logic [2:0]  C_RUN_MAX         = 3'd6;

    // reciprocals: x/1500 = (x*R)>>32, x/10 = (x*R)>>26, x/5 = (x*R)>>17
    localparam logic [21:0] C_RECIP_1500 = 22'd2863312;
    localparam logic [22:0] C_RECIP_10   = 23'd6710887;
    localparam logic [14:0] C_RECIP_5    = 15'd26215;

    localparam logic [8:0]  C_BASE_SPEED = 9'd280;
    localparam logic [8:0]  C_BASE_MIN   = 9'd160;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ERROR,
        ST_PD,
        ST_SCALE,
        ST_CMD,
        ST_FSUM,
        ST_FDIV,
        ST_CMUL,
        ST_CDIV,
        ST_DRIVE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic err_step;
        logic pd_step;
        logic scale_step;
        logic cmd_step;
        logic fsum_step;
        logic fdiv_step;
        logic cmul_step;
        logic cdiv_step;
        logic drive_step;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/core/lfpd_ctrl.sv =====
`default_nettype none
module lfpd_ctrl
    import lfpd_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_cnt = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                n_div_cnt = r_div_cnt + 4'd1;
                if (r_div_cnt == 4'(C_DIV_STEPS - 1)) n_state = ST_ERROR;
            end
            ST_ERROR: n_state = ST_PD;
            ST_PD:    n_state = ST_SCALE;
            ST_SCALE: n_state = ST_CMD;
            ST_CMD:   n_state = ST_FSUM;
            ST_FSUM:  n_state = ST_FDIV;
            ST_FDIV:  n_state = ST_CMUL;
            ST_CMUL:  n_state = ST_CDIV;
            ST_CDIV:  n_state = ST_DRIVE;
            ST_DRIVE: begin
                // hold until the output register can take the beat
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIVIDE: o_cmd.div_step   = 1'b1;
            ST_ERROR:  o_cmd.err_step   = 1'b1;
            ST_PD:     o_cmd.pd_step    = 1'b1;
            ST_SCALE:  o_cmd.scale_step = 1'b1;
            ST_CMD:    o_cmd.cmd_step   = 1'b1;
            ST_FSUM:   o_cmd.fsum_step  = 1'b1;
            ST_FDIV:   o_cmd.fdiv_step  = 1'b1;
            ST_CMUL:   o_cmd.cmul_step  = 1'b1;
            ST_CDIV:   o_cmd.cdiv_step  = 1'b1;
            ST_DRIVE:  o_cmd.drive_step = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/lfpd_dp.sv =====
`default_nettype none
module lfpd_dp
    import lfpd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  wire  [7:0]         i_sensor_bits,
    input  wire  [9:0]         i_speed_scale,
    input  wire                i_reverse,
    input  wire                i_clear_pid,
    input  wire                i_cfg_we,
    input  wire  [11:0]        i_cfg_wdata,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output logic signed [12:0] o_left_drive,
    output logic signed [12:0] o_right_drive,
    output logic               o_crossing_seen,
    output logic               o_line_latched,
    output logic [3:0]         o_lit_count
);

    function automatic logic signed [12:0] clamp_drive(
        input logic signed [13:0] v,
        input logic signed [13:0] lim
    );
        logic signed [13:0] r;
        begin
            r = v;
            if (v > lim) r = lim;
            if (v < -lim) r = -lim;
            return r[12:0];
        end
    endfunction

    // state and configuration
    logic [11:0]        r_limit;
    logic signed [11:0] r_last;
    logic signed [19:0] r_filt;
    logic [2:0]         r_run;
    logic               r_latch;

    // per-item working registers
    logic [9:0]         r_speed;
    logic               r_rev;
    logic [3:0]         r_cnt;
    logic               r_cross;
    logic               r_neg;
    logic [3:0]         r_rem;
    logic [11:0]        r_quo;
    logic signed [11:0] r_err;
    logic signed [12:0] r_d;
    logic signed [19:0] r_pd;
    logic [29:0]        r_pmag;
    logic               r_psign;
    logic signed [11:0] r_cmd;
    logic signed [23:0] r_fv;
    logic [30:0]        r_cmag;
    logic               r_csign;
    logic signed [12:0] r_corr;

    // output register
    logic               r_out_valid;
    logic signed [12:0] r_left, r_right;
    logic               r_out_cross, r_out_latch;
    logic [3:0]         r_out_cnt;

    // scan decode
    logic signed [5:0]  sum;
    logic [3:0]         cnt;
    logic signed [5:0]  sum_abs_w;
    logic [11:0]        dividend;

    always_comb begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < C_NUM_SENSORS; i++) begin
            if (i_sensor_bits[i]) begin
                sum = sum + 6'(C_WEIGHT_HALVES[i]);
                cnt = cnt + 4'd1;
            end
        end
        sum_abs_w = (sum < 0) ? -sum : sum;
        dividend  = {sum_abs_w[4:0], 7'b0};
    end

    // restoring divide, one quotient bit a cycle
    logic [4:0] div_t;
    logic       div_ge;
    assign div_t  = {r_rem, r_quo[11]};
    assign div_ge = (div_t >= {1'b0, r_cnt});

    // error and derivative
    logic signed [11:0] err_new;
    logic signed [12:0] d_new;
    assign err_new = (r_cnt == 4'd0) ? r_last
                   : (r_neg ? -$signed(r_quo) : $signed(r_quo));
    assign d_new   = 13'(err_new) - 13'(r_last);

    logic [11:0] err_abs_w;
    logic [10:0] err_abs;
    assign err_abs_w = (r_err < 0) ? 12'(-r_err) : 12'(r_err);
    assign err_abs   = err_abs_w[10:0];

    // speed scaling
    logic [19:0] pd_abs_w;
    logic [10:0] spd1;
    assign pd_abs_w = (r_pd < 0) ? 20'(-r_pd) : 20'(r_pd);
    assign spd1     = 11'(r_speed) + 11'd1;

    logic [43:0] cmd_prod;
    logic [11:0] cmd_q;
    assign cmd_prod = 44'(r_pmag[29:8]) * 44'(C_RECIP_1500);
    assign cmd_q    = cmd_prod[43:32];

    // low-pass filter
    logic [23:0] fv_abs_w;
    logic [45:0] fdiv_prod;
    logic [19:0] fdiv_q;
    assign fv_abs_w  = (r_fv < 0) ? 24'(-r_fv) : 24'(r_fv);
    assign fdiv_prod = 46'(fv_abs_w[22:0]) * 46'(C_RECIP_10);
    assign fdiv_q    = fdiv_prod[45:26];

    // correction factor
    logic [19:0] filt_abs_w;
    logic [11:0] factor;
    assign filt_abs_w = (r_filt < 0) ? 20'(-r_filt) : 20'(r_filt);
    assign factor     = 12'd1280 + 12'(err_abs);

    logic [29:0] cdiv_prod;
    logic [12:0] cdiv_q;
    assign cdiv_prod = 30'(r_cmag[30:16]) * 30'(C_RECIP_5);
    assign cdiv_q    = cdiv_prod[29:17];

    // drives
    logic [15:0]        e35;
    logic [8:0]         base_raw, base;
    logic signed [13:0] base_s, corr_s, lim_s;
    logic signed [12:0] left_c, right_c;
    assign e35      = 16'(err_abs) * 16'd35;
    assign base_raw = C_BASE_SPEED - 9'(e35[15:8]);
    assign base     = (base_raw < C_BASE_MIN) ? C_BASE_MIN : base_raw;
    assign base_s   = $signed(14'(base));
    assign corr_s   = 14'(r_corr);
    assign lim_s    = $signed(14'(r_limit));
    assign left_c   = clamp_drive(base_s + corr_s, lim_s);
    assign right_c  = clamp_drive(base_s - corr_s, lim_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= C_DRIVE_LIMIT_RST;
            r_last      <= '0;
            r_filt      <= '0;
            r_run       <= '0;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;

            if (i_cmd.load) begin
                if (i_clear_pid) r_last <= '0;
                if (cnt != 4'd0) begin
                    if (r_run < C_RUN_MAX) begin
                        r_run <= r_run + 3'd1;
                    end else if (i_sensor_bits[3] || i_sensor_bits[4]) begin
                        r_latch <= 1'b1;
                    end
                end else begin
                    r_run <= '0;
                end
            end

            if (i_cmd.err_step) r_last <= err_new;

            if (i_cmd.fdiv_step) begin
                r_filt <= r_fv[23] ? -$signed(fdiv_q) : $signed(fdiv_q);
            end

            if (i_cmd.drive_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_speed <= i_speed_scale;
            r_rev   <= i_reverse;
            r_cnt   <= cnt;
            r_cross <= (cnt > 4'd3) || (cnt == 4'd0);
            r_neg   <= sum[5];
            r_rem   <= '0;
            r_quo   <= dividend;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? 4'(div_t - {1'b0, r_cnt}) : div_t[3:0];
            r_quo <= {r_quo[10:0], div_ge};
        end
        if (i_cmd.err_step) begin
            r_err <= err_new;
            r_d   <= d_new;
        end
        if (i_cmd.pd_step) begin
            r_pd <= 20'(r_err) * 20'sd350 + 20'(r_d) * 20'sd49;
        end
        if (i_cmd.scale_step) begin
            r_pmag  <= 30'(pd_abs_w[18:0]) * 30'(spd1);
            r_psign <= r_pd[19];
        end
        if (i_cmd.cmd_step) begin
            // command is the negated scaled PD term
            r_cmd <= r_psign ? $signed(cmd_q) : -$signed(cmd_q);
        end
        if (i_cmd.fsum_step) begin
            r_fv <= 24'(r_filt) * 24'sd7 + 24'(r_cmd) * 24'sd768;
        end
        if (i_cmd.cmul_step) begin
            r_cmag  <= 31'(filt_abs_w[18:0]) * 31'(factor);
            r_csign <= r_filt[19];
        end
        if (i_cmd.cdiv_step) begin
            r_corr <= r_csign ? -$signed(cdiv_q) : $signed(cdiv_q);
        end
        if (i_cmd.drive_step) begin
            r_left      <= r_rev ? right_c : left_c;
            r_right     <= r_rev ? left_c : right_c;
            r_out_cross <= r_cross;
            r_out_latch <= r_latch;
            r_out_cnt   <= r_cnt;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_left_drive    = r_left;
    assign o_right_drive   = r_right;
    assign o_crossing_seen = r_out_cross;
    assign o_line_latched  = r_out_latch;
    assign o_lit_count     = r_out_cnt;

endmodule
`default_nettype wire

// ===== rtl/core/line_follow_pd_steering_unit.sv =====
// Line-follow PD steering unit.
// Slave stream: one beat per sensor scan. s_axis_tdata carries the sensor
// bits and the speed value; s_axis_tuser carries reverse and clear_pid.
// Master stream: one beat per scan with the saturated left and right wheel
// drives, the lit-sensor count, and the crossing and centre-line flags.
// Config: pulse i_cfg_we with i_cfg_wdata to set the drive limit (reset 500);
// write it only while no scan is in flight.
// Flow: the scan is decoded at the accepting edge, then the weighted sum is
// divided by the lit count in a bit-serial restoring divide, followed by
// single steps through the error, PD, speed scaling, command, filter,
// correction and drive stages. The unit then returns to idle; a new scan is
// taken only once the last one is through.
// The output register holds a finished beat while the next scan is worked
// on; if the receiver still stalls when the following result is ready, the
// unit waits and s_axis_tready stays low until the register drains.
// Reset clears the error history, filter, line-run counter, centre-line
// latch and the output valid, and restores the drive limit.
`default_nettype none
module line_follow_pd_steering_unit
    import lfpd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // sensor_bits[7:0], speed_scale[17:8], zero pad
    input  wire  [1:0]  s_axis_tuser,   // reverse[0], clear_pid[1]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_drive[12:0], right_drive[25:13],
                                        // lit_count[29:26], zero pad
    output logic [1:0]  m_axis_tuser,   // crossing_seen[0], line_latched[1]
    input  wire         i_cfg_we,
    input  wire  [11:0] i_cfg_wdata
);

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic signed [12:0] left_drive, right_drive;
    logic               crossing_seen, line_latched;
    logic [3:0]         lit_count;

    lfpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfpd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sensor_bits   (s_axis_tdata[7:0]),
        .i_speed_scale   (s_axis_tdata[17:8]),
        .i_reverse       (s_axis_tuser[0]),
        .i_clear_pid     (s_axis_tuser[1]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_left_drive    (left_drive),
        .o_right_drive   (right_drive),
        .o_crossing_seen (crossing_seen),
        .o_line_latched  (line_latched),
        .o_lit_count     (lit_count)
    );

    assign m_axis_tdata = {2'b00, lit_count, right_drive, left_drive};
    assign m_axis_tuser = {line_latched, crossing_seen};

endmodule
`default_nettype wire
